// File: design/abst_pkg.sv
// Shared types and codes for the array-held binary search tree.
// Used by the datapath, the controller, the top level and the checker.
package abst_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned STAT_W = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the accepted item, restart the walk at the root
    logic clr_wr;   // clear one slot of the clearing pass
    logic rd;       // read the slot under the walk index
    logic descend;  // move to the left or right child
    logic set_hit;  // mark the walk as stopped on an equal key
    logic finish;   // write back on insert and load the result register
  } abst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_range;   // walk index below the slot count
    logic node_valid; // slot just read holds a key
    logic node_eq;    // that key equals the item's key
    logic out_free;   // result register can take a new item
    logic clr_last;   // clearing pass is at its last slot
  } abst_sts_t;

endpackage

// File: design/abst_dp.sv
// Datapath of the array-held binary search tree: slot memory, walk index,
// compare and the result register. Depends on abst_pkg.
module abst_dp #(
  parameter int unsigned TREE_SLOTS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abst_pkg::in_item_t    in_data_i,
  input  abst_pkg::abst_cmd_t   cmd_i,
  output abst_pkg::abst_sts_t   sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output abst_pkg::out_item_t   out_data_o
);

  localparam int unsigned IW = $clog2(2 * TREE_SLOTS + 1);
  localparam int unsigned AW = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
  localparam int unsigned MW = abst_pkg::KEY_W + 1;

  logic                              cmd_q;
  logic signed [abst_pkg::KEY_W-1:0] key_q;
  logic [IW-1:0]                     idx_q;
  logic                              hit_q;
  logic [AW-1:0]                     clr_q;
  logic [MW-1:0]                     mem [TREE_SLOTS];
  logic [MW-1:0]                     rd_q;
  logic                              out_valid_q;
  abst_pkg::out_item_t               out_q;

  logic signed [abst_pkg::KEY_W-1:0] node_key;
  logic                              node_lt;
  logic                              in_range;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [MW-1:0]                     wdata;
  abst_pkg::out_item_t               res;

  assign node_key = $signed(rd_q[abst_pkg::KEY_W-1:0]);
  assign node_lt  = key_q < node_key;
  assign in_range = idx_q < IW'(TREE_SLOTS);

  assign sts_o.in_range   = in_range;
  assign sts_o.node_valid = rd_q[MW-1];
  assign sts_o.node_eq    = (rd_q[abst_pkg::KEY_W-1:0] == key_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.clr_last   = (clr_q == AW'(TREE_SLOTS - 1));

  always_comb begin
    res.slot_index = '0;
    if (cmd_q == abst_pkg::CMD_INSERT) begin
      if (hit_q) begin
        res.status = abst_pkg::ST_DUPLICATE;
      end else if (in_range) begin
        res.status     = abst_pkg::ST_INSERTED;
        res.slot_index = abst_pkg::SLOT_W'(idx_q);
      end else begin
        res.status = abst_pkg::ST_NO_ROOM;
      end
    end else begin
      if (hit_q) begin
        res.status     = abst_pkg::ST_FOUND;
        res.slot_index = abst_pkg::SLOT_W'(idx_q);
      end else begin
        res.status = abst_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign we    = cmd_i.clr_wr ||
                 (cmd_i.finish && (cmd_q == abst_pkg::CMD_INSERT) && !hit_q && in_range);
  assign waddr = cmd_i.clr_wr ? clr_q : idx_q[AW-1:0];
  assign wdata = cmd_i.clr_wr ? '0 : {1'b1, key_q};

  // Slot memory: valid bit and key per word, one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_data_i.command;
      key_q <= in_data_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.descend) begin
        idx_q <= (idx_q << 1) + (node_lt ? IW'(1) : IW'(2));
      end
      if (cmd_i.set_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/abst_ctrl.sv
// Controller of the array-held binary search tree: clearing pass and the
// per-level read and compare sequence. Depends on abst_pkg.
module abst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abst_pkg::abst_sts_t sts_i,
  output abst_pkg::abst_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_LOOKUP  = 3'd2;
  localparam logic [2:0] S_COMPARE = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts_i.in_range) begin
          cmd_o.rd = 1'b1;
          state_d  = S_COMPARE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_COMPARE: begin
        priority if (!sts_i.node_valid) begin
          state_d = S_FINISH;
        end else if (sts_i.node_eq) begin
          cmd_o.set_hit = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.descend = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/array_bst_insert_search.sv
// Each accepted item walks the tree from the root: every slot on its path is
// read (LOOKUP) and compared (COMPARE); the walk ends in FINISH, also when it
// runs past the last slot. FINISH waits while the sink holds a result; the next
// item is taken the cycle after the result is registered.
// Reset: asynchronous, active low; afterwards a clearing pass writes every slot
// empty before the first item is accepted.
module array_bst_insert_search #(
  parameter int unsigned TREE_SLOTS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output abst_pkg::out_item_t out_data_o
);

  // Command and status bundles between the sequencer and the datapath.
  abst_pkg::abst_cmd_t cmd;
  abst_pkg::abst_sts_t sts;

  // Sequencer: hold off items during the clearing pass, then walk the tree
  // level by level, read a slot, compare, descend or stop.
  abst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: slot memory with a valid bit per word, walk index, key
  // compare and the output register that decouples the result from the walk.
  abst_dp #(
    .TREE_SLOTS (TREE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/abst_chk.sv
// Port-level checker for the array-held binary search tree, with its bind.
// Depends on abst_pkg and the top level array_bst_insert_search.
module abst_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input abst_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input abst_pkg::out_item_t out_data_o
);

  // A result held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One item at a time: no second item right after an acceptance.
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during a walk");

  // Status stays within its codes.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= abst_pkg::ST_NOT_FOUND)
    else $error("status code out of range");

  // Slot index is zero unless a slot was written or found.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == abst_pkg::ST_DUPLICATE ||
                    out_data_o.status == abst_pkg::ST_NO_ROOM ||
                    out_data_o.status == abst_pkg::ST_NOT_FOUND)
    |-> out_data_o.slot_index == '0)
    else $error("slot index set on a miss");

endmodule

bind array_bst_insert_search abst_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
